@@ hdl/asi_pkg.sv @@
package asi_pkg;

   localparam int RAW_W = 10;

   localparam logic [2:0] CMD_EXEC  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_ABORT = 3'd2;
   localparam logic [2:0] CMD_PROP  = 3'd3;
   localparam logic [2:0] CMD_ARM   = 3'd4;
   localparam logic [2:0] CMD_SERVO = 3'd5;
   localparam logic [2:0] CMD_WVAR  = 3'd6;
   localparam logic [2:0] CMD_WSEQ  = 3'd7;

   localparam logic [7:0] OP_NOP     = 8'd0;
   localparam logic [7:0] OP_MOV1    = 8'd1;
   localparam logic [7:0] OP_MOV2    = 8'd2;
   localparam logic [7:0] OP_MOV3    = 8'd3;
   localparam logic [7:0] OP_MOVI    = 8'd4;
   localparam logic [7:0] OP_ADDI    = 8'd8;
   localparam logic [7:0] OP_SUBI    = 8'd9;
   localparam logic [7:0] OP_ADD     = 8'd10;
   localparam logic [7:0] OP_SUB     = 8'd11;
   localparam logic [7:0] OP_RET     = 8'd30;
   localparam logic [7:0] OP_CALL    = 8'd31;
   localparam logic [7:0] OP_DELAY   = 8'd32;
   localparam logic [7:0] OP_YIELD   = 8'd33;
   localparam logic [7:0] OP_EVENT   = 8'd34;
   localparam logic [7:0] OP_MOTEN   = 8'd64;
   localparam logic [7:0] OP_PROPEN  = 8'd65;
   localparam logic [7:0] OP_MOTDIS  = 8'd66;
   localparam logic [7:0] OP_PROPDIS = 8'd67;
   localparam logic [7:0] OP_TRAJ    = 8'd120;
   localparam logic [7:0] OP_WAITARM = 8'd125;
   localparam logic [7:0] OP_WAITMOV = 8'd126;
   localparam logic [7:0] OP_SETPOSE = 8'd127;
   localparam logic [7:0] OP_POINT   = 8'd128;
   localparam logic [7:0] OP_MOVE    = 8'd129;
   localparam logic [7:0] OP_ROT     = 8'd130;
   localparam logic [7:0] OP_TRANS   = 8'd131;
   localparam logic [7:0] OP_REPOS   = 8'd132;
   localparam logic [7:0] OP_MANIN   = 8'd133;
   localparam logic [7:0] OP_MANOUT  = 8'd134;
   localparam logic [7:0] OP_CTRL    = 8'd135;
   localparam logic [7:0] OP_TGT     = 8'd136;
   localparam logic [7:0] OP_FACE    = 8'd137;
   localparam logic [7:0] OP_ADV     = 8'd138;
   localparam logic [7:0] OP_MEASN   = 8'd139;
   localparam logic [7:0] OP_DC      = 8'd140;
   localparam logic [7:0] OP_ARMGO   = 8'd141;
   localparam logic [7:0] OP_SRVSET  = 8'd142;
   localparam logic [7:0] OP_ARMSD   = 8'd143;
   localparam logic [7:0] OP_DCB     = 8'd144;
   localparam logic [7:0] OP_GPIO    = 8'd145;
   localparam logic [7:0] OP_WAITSRV = 8'd146;
   localparam logic [7:0] OP_MEASP   = 8'd147;
   localparam logic [7:0] OP_SENSOR  = 8'd150;
   localparam logic [7:0] OP_PROPST  = 8'd151;
   localparam logic [7:0] OP_POSE    = 8'd152;
   localparam logic [7:0] OP_CMP     = 8'd160;
   localparam logic [7:0] OP_JMP     = 8'd200;
   localparam logic [7:0] OP_JZ      = 8'd201;
   localparam logic [7:0] OP_JNZ     = 8'd202;
   localparam logic [7:0] OP_JN      = 8'd203;

   localparam logic [4:0] MK_NONE    = 5'd0;
   localparam logic [4:0] MK_PROPEN  = 5'd1;
   localparam logic [4:0] MK_SETPOSE = 5'd2;
   localparam logic [4:0] MK_POINT   = 5'd3;
   localparam logic [4:0] MK_MOVE    = 5'd4;
   localparam logic [4:0] MK_TRAJ    = 5'd5;
   localparam logic [4:0] MK_ROT     = 5'd6;
   localparam logic [4:0] MK_TRANS   = 5'd7;
   localparam logic [4:0] MK_REPOS   = 5'd8;
   localparam logic [4:0] MK_MANIN   = 5'd9;
   localparam logic [4:0] MK_MANOUT  = 5'd10;
   localparam logic [4:0] MK_CTRL    = 5'd11;
   localparam logic [4:0] MK_TGT     = 5'd12;
   localparam logic [4:0] MK_FACE    = 5'd13;
   localparam logic [4:0] MK_ADV     = 5'd14;
   localparam logic [4:0] MK_MEASN   = 5'd15;
   localparam logic [4:0] MK_MEASP   = 5'd16;
   localparam logic [4:0] MK_DC      = 5'd17;
   localparam logic [4:0] MK_ARMGO   = 5'd18;
   localparam logic [4:0] MK_SERVO   = 5'd19;
   localparam logic [4:0] MK_ARMSD   = 5'd20;
   localparam logic [4:0] MK_GPIO    = 5'd21;

   localparam logic [7:0] PROP_STOPPED = 8'd1;

   typedef struct packed {
      logic             capture;
      logic             step;
      logic             commit;
      logic             load;
      logic             phase_c;
      logic [5:0]       idx;
   } ctl_type;

   typedef struct packed {
      logic [1:0]       num_steps;
      logic [5:0]       num_words;
      logic             out_free;
   } sts_type;

   typedef struct packed {
      logic             use_var;
      logic             low16;
      logic [RAW_W-1:0] addr;
      logic [31:0]      cst;
   } pw_type;

   function automatic logic [4:0] pay_kind(logic [7:0] op);
      logic [4:0] k;
      k = MK_NONE;
      case (op) inside
         OP_PROPEN, OP_PROPDIS: k = MK_PROPEN;
         OP_SETPOSE:            k = MK_SETPOSE;
         OP_POINT:              k = MK_POINT;
         OP_MOVE:               k = MK_MOVE;
         OP_TRAJ:               k = MK_TRAJ;
         OP_ROT:                k = MK_ROT;
         OP_TRANS:              k = MK_TRANS;
         OP_FACE:               k = MK_FACE;
         OP_REPOS:              k = MK_REPOS;
         OP_MANIN:              k = MK_MANIN;
         OP_MANOUT:             k = MK_MANOUT;
         OP_CTRL:               k = MK_CTRL;
         OP_TGT:                k = MK_TGT;
         OP_ADV:                k = MK_ADV;
         OP_MEASN:              k = MK_MEASN;
         OP_MEASP:              k = MK_MEASP;
         OP_DC, OP_DCB:         k = MK_DC;
         OP_GPIO:               k = MK_GPIO;
         OP_ARMGO:              k = MK_ARMGO;
         OP_SRVSET:             k = MK_SERVO;
         OP_ARMSD:              k = MK_ARMSD;
         default:               k = MK_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [5:0] pay_count(logic [7:0] op, logic [7:0] b, int max_pts);
      logic [4:0] n;
      logic [5:0] c;
      n = (int'(b) > max_pts) ? 5'(max_pts) : b[4:0];
      c = 6'd0;
      case (op) inside
         OP_PROPEN, OP_PROPDIS, OP_CTRL, OP_ADV:   c = 6'd1;
         OP_DC, OP_DCB, OP_GPIO, OP_ARMGO, OP_SRVSET: c = 6'd1;
         OP_SETPOSE:                               c = 6'd3;
         OP_POINT, OP_MOVE:                        c = 6'd5;
         OP_TRAJ:                                  c = 6'd3 + {n, 1'b0};
         OP_ROT, OP_TRANS, OP_FACE, OP_MEASP:      c = 6'd4;
         OP_REPOS, OP_MEASN:                       c = 6'd2;
         OP_TGT:                                   c = 6'd7;
         default:                                  c = 6'd0;
      endcase
      return c;
   endfunction

   function automatic pw_type pay_sel(logic [7:0] op, logic [5:0] k,
                                      logic [7:0] a, logic [7:0] b, logic [7:0] c);
      pw_type p;
      logic [RAW_W-1:0] ak;
      logic [RAW_W-1:0] bk;
      p  = '0;
      ak = RAW_W'(a) + RAW_W'(k);
      bk = RAW_W'(b) + RAW_W'(k);
      case (op) inside
         OP_PROPEN:  p.cst = 32'd1;
         OP_SETPOSE, OP_MEASN: begin
            p.use_var = 1'b1;
            p.addr = ak;
         end
         OP_POINT, OP_MOVE, OP_MEASP: begin
            p.use_var = 1'b1;
            p.addr = (k < 6'd2) ? ak : bk - RAW_W'(2);
         end
         OP_TRAJ: begin
            p.use_var = 1'b1;
            p.addr = (k < 6'd3) ? RAW_W'(c) + RAW_W'(k) : ak - RAW_W'(3);
         end
         OP_ROT, OP_TRANS, OP_FACE: begin
            p.use_var = 1'b1;
            p.addr = (k == 6'd0) ? RAW_W'(a) : bk - RAW_W'(1);
         end
         OP_REPOS: begin
            p.use_var = 1'b1;
            p.addr = (k == 6'd0) ? RAW_W'(a) : RAW_W'(b);
         end
         OP_TGT: begin
            p.use_var = (k < 6'd5);
            p.addr = (k < 6'd3) ? ak : bk - RAW_W'(3);
         end
         OP_CTRL, OP_GPIO: p.cst = {16'd0, b, a};
         OP_ADV:     p.cst = {24'd0, a};
         OP_ARMGO:   p.cst = {8'd0, c, b, a};
         OP_DC: begin
            p.use_var = 1'b1;
            p.low16 = 1'b1;
            p.addr = RAW_W'(a);
         end
         OP_DCB: begin
            p.use_var = 1'b1;
            p.low16 = 1'b1;
            p.addr = RAW_W'(b);
            p.cst = {24'd0, a};
         end
         OP_SRVSET: begin
            p.use_var = 1'b1;
            p.low16 = 1'b1;
            p.addr = RAW_W'(b);
            p.cst = {c, 16'd0, a};
         end
         default: p = '0;
      endcase
      return p;
   endfunction

endpackage

@@ hdl/actuator_sequence_interpreter.sv @@
// Script instruction interpreter for a robot sequencer.
// Request channel (req_*): one item is a command with its instruction
// fields, taken when req_valid is high and req_stall is low. Response
// channel (rsp_*): one item per payload word of the message the command
// causes, at least one, with rsp_last_word on the final one.
// After acceptance the block passes through a read state and a step state
// for each variable read or write step of the instruction (up to 3), then
// a final read state and the commit state. Each payload word takes one
// variable memory read, then the output register load; req_stall is high
// from acceptance until the last word of the item is loaded.
// Reset clears the program counter, run flag, flags, stack level, delay
// and actuator status; variable, sequence start and stack memories hold
// whatever was last written. A stalled response holds its register and
// the block waits before loading the next word; the last word of an item
// may wait in the output register while the next request is taken.
module actuator_sequence_interpreter #(
   parameter int NUM_VARIABLES   = 256,
   parameter int NUM_SEQUENCES   = 64,
   parameter int STACK_DEPTH     = 16,
   parameter int NUM_SERVOS      = 16,
   parameter int MAX_TRAJ_POINTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_opcode,
   input  logic [7:0]  req_arg_a,
   input  logic [7:0]  req_arg_b,
   input  logic [7:0]  req_arg_c,
   input  logic [31:0] req_data_value,
   input  logic [7:0]  req_status_value,
   input  logic [31:0] req_tick_now,
   input  logic [31:0] req_sensor_bits,
   input  logic [31:0] req_pose_x,
   input  logic [31:0] req_pose_y,
   input  logic [31:0] req_pose_yaw,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_program_counter,
   output logic        rsp_running,
   output logic        rsp_continue_now,
   output logic [4:0]  rsp_message_kind,
   output logic [31:0] rsp_payload_word,
   output logic        rsp_last_word,
   output logic        rsp_flag_zero,
   output logic        rsp_flag_negative
);
   import asi_pkg::*;

   ctl_type ctl;
   sts_type sts;

   asi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   asi_dpath #(
      .NUM_VARIABLES   (NUM_VARIABLES),
      .NUM_SEQUENCES   (NUM_SEQUENCES),
      .STACK_DEPTH     (STACK_DEPTH),
      .NUM_SERVOS      (NUM_SERVOS),
      .MAX_TRAJ_POINTS (MAX_TRAJ_POINTS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .sts                 (sts),
      .req_command         (req_command),
      .req_opcode          (req_opcode),
      .req_arg_a           (req_arg_a),
      .req_arg_b           (req_arg_b),
      .req_arg_c           (req_arg_c),
      .req_data_value      (req_data_value),
      .req_status_value    (req_status_value),
      .req_tick_now        (req_tick_now),
      .req_sensor_bits     (req_sensor_bits),
      .req_pose_x          (req_pose_x),
      .req_pose_y          (req_pose_y),
      .req_pose_yaw        (req_pose_yaw),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_program_counter (rsp_program_counter),
      .rsp_running         (rsp_running),
      .rsp_continue_now    (rsp_continue_now),
      .rsp_message_kind    (rsp_message_kind),
      .rsp_payload_word    (rsp_payload_word),
      .rsp_last_word       (rsp_last_word),
      .rsp_flag_zero       (rsp_flag_zero),
      .rsp_flag_negative   (rsp_flag_negative)
   );

endmodule

@@ hdl/asi_ram.sv @@
module asi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/asi_ctrl.sv @@
module asi_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  asi_pkg::sts_type  sts,
   output asi_pkg::ctl_type  ctl
);
   import asi_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_ARD, S_AEX, S_COMMIT, S_PRD, S_PEMIT
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] k_ff, k_in;

   always_comb begin
      state_in    = state_ff;
      k_in        = k_ff;
      ctl         = '0;
      ctl.idx     = k_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.capture = 1'b1;
               k_in        = 6'd0;
               state_in    = S_ARD;
            end
         end
         S_ARD: begin
            state_in = (k_ff == {4'd0, sts.num_steps}) ? S_COMMIT : S_AEX;
         end
         S_AEX: begin
            ctl.step = 1'b1;
            k_in     = k_ff + 6'd1;
            state_in = S_ARD;
         end
         S_COMMIT: begin
            ctl.commit = 1'b1;
            k_in       = 6'd0;
            state_in   = S_PRD;
         end
         S_PRD: begin
            ctl.phase_c = 1'b1;
            state_in    = S_PEMIT;
         end
         S_PEMIT: begin
            ctl.phase_c = 1'b1;
            if (sts.out_free) begin
               ctl.load = 1'b1;
               if (k_ff == sts.num_words - 6'd1) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + 6'd1;
                  state_in = S_PRD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= 6'd0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

@@ hdl/asi_dpath.sv @@
module asi_dpath #(
   parameter int NUM_VARIABLES   = 256,
   parameter int NUM_SEQUENCES   = 64,
   parameter int STACK_DEPTH     = 16,
   parameter int NUM_SERVOS      = 16,
   parameter int MAX_TRAJ_POINTS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  asi_pkg::ctl_type  ctl,
   output asi_pkg::sts_type  sts,
   input  logic [2:0]        req_command,
   input  logic [7:0]        req_opcode,
   input  logic [7:0]        req_arg_a,
   input  logic [7:0]        req_arg_b,
   input  logic [7:0]        req_arg_c,
   input  logic [31:0]       req_data_value,
   input  logic [7:0]        req_status_value,
   input  logic [31:0]       req_tick_now,
   input  logic [31:0]       req_sensor_bits,
   input  logic [31:0]       req_pose_x,
   input  logic [31:0]       req_pose_y,
   input  logic [31:0]       req_pose_yaw,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [15:0]       rsp_program_counter,
   output logic              rsp_running,
   output logic              rsp_continue_now,
   output logic [4:0]        rsp_message_kind,
   output logic [31:0]       rsp_payload_word,
   output logic              rsp_last_word,
   output logic              rsp_flag_zero,
   output logic              rsp_flag_negative
);
   import asi_pkg::*;

   localparam int VAR_AW = $clog2(NUM_VARIABLES);
   localparam int SEQ_AW = (NUM_SEQUENCES > 1) ? $clog2(NUM_SEQUENCES) : 1;
   localparam int STK_AW = $clog2(STACK_DEPTH);
   localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
   localparam int SRV_AW = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;

   logic [2:0]  cmd_ff;
   logic [7:0]  op_ff, a_ff, b_ff, c_ff, sv_ff;
   logic [31:0] data_ff, tick_ff, sens_ff, px_ff, py_ff, pw_ff;

   logic [15:0]      pc_ff;
   logic             run_ff, zf_ff, nf_ff, cont_ff;
   logic [31:0]      dend_ff;
   logic             dval_ff;
   logic [7:0]       pcode_ff;
   logic             ppend_ff, aidle_ff, apend_ff;
   logic             srv_ff [NUM_SERVOS];
   logic [LVL_W-1:0] lvl_ff;
   logic [4:0]       kind_ff;
   logic [5:0]       npay_ff;
   logic [31:0]      t0_ff, t1_ff;

   logic             rsp_valid_ff;
   logic [15:0]      rsp_pc_ff;
   logic             rsp_run_ff, rsp_cont_ff, rsp_last_ff, rsp_z_ff, rsp_n_ff;
   logic [4:0]       rsp_kind_ff;
   logic [31:0]      rsp_word_ff;

   logic             exec_on;
   pw_type           pw;
   logic [RAW_W-1:0] var_raddr, var_waddr;
   logic             var_we_raw;
   logic [31:0]      var_wdata, var_rd, v;
   logic             a_seq_ok, a_srv_ok, srv_hit;
   logic [15:0]      seq_rd, seq_val, stk_rd, nxt, target;
   logic [LVL_W-1:0] lvl_dec;
   logic             call_ok;
   logic [31:0]      word;
   logic [5:0]       num_words;

   assign exec_on  = (cmd_ff == CMD_EXEC) && run_ff;
   assign pw       = pay_sel(op_ff, ctl.idx, a_ff, b_ff, c_ff);
   assign a_seq_ok = (int'(a_ff) < NUM_SEQUENCES);
   assign a_srv_ok = (int'(a_ff) < NUM_SERVOS);
   assign srv_hit  = a_srv_ok && srv_ff[a_ff[SRV_AW-1:0]];
   assign seq_val  = a_seq_ok ? seq_rd : 16'd0;
   assign nxt      = pc_ff + 16'd1;
   assign target   = {b_ff, a_ff};
   assign lvl_dec  = lvl_ff - LVL_W'(1);
   assign call_ok  = (int'(lvl_ff) < STACK_DEPTH);

   always_comb begin
      var_raddr = RAW_W'(a_ff);
      if (ctl.phase_c) begin
         var_raddr = pw.addr;
      end else begin
         case (op_ff) inside
            OP_MOV1, OP_MOV2, OP_MOV3: var_raddr = RAW_W'(b_ff) + RAW_W'(ctl.idx);
            OP_ADD, OP_SUB:   var_raddr = (ctl.idx == 6'd0) ? RAW_W'(b_ff) : RAW_W'(c_ff);
            OP_CMP:           var_raddr = (ctl.idx == 6'd0) ? RAW_W'(a_ff) : RAW_W'(b_ff);
            default:          var_raddr = RAW_W'(a_ff);
         endcase
      end
   end

   assign v = (int'(var_raddr) < NUM_VARIABLES) ? var_rd : 32'd0;

   always_comb begin
      sts.num_steps = 2'd0;
      if (exec_on) begin
         case (op_ff) inside
            OP_MOV1, OP_MOVI, OP_ADDI, OP_SUBI: sts.num_steps = 2'd1;
            OP_MOV2, OP_ADD, OP_SUB, OP_CMP:    sts.num_steps = 2'd2;
            OP_MOV3, OP_POSE:                   sts.num_steps = 2'd3;
            OP_DELAY:                           sts.num_steps = dval_ff ? 2'd0 : 2'd1;
            default:                            sts.num_steps = 2'd0;
         endcase
      end
   end

   assign num_words     = (npay_ff == 6'd0) ? 6'd1 : npay_ff;
   assign sts.num_words = num_words;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      var_we_raw = 1'b0;
      var_waddr  = RAW_W'(a_ff);
      var_wdata  = v;
      if (ctl.step && exec_on) begin
         case (op_ff) inside
            OP_MOV1, OP_MOV2, OP_MOV3: begin
               var_we_raw = 1'b1;
               var_waddr  = RAW_W'(a_ff) + RAW_W'(ctl.idx);
            end
            OP_MOVI: begin
               var_we_raw = 1'b1;
               var_wdata  = {24'd0, b_ff};
            end
            OP_ADDI: begin
               var_we_raw = 1'b1;
               var_wdata  = v + {24'd0, b_ff};
            end
            OP_SUBI: begin
               var_we_raw = 1'b1;
               var_wdata  = v - {24'd0, b_ff};
            end
            OP_ADD: begin
               var_we_raw = (ctl.idx == 6'd1);
               var_wdata  = t0_ff + v;
            end
            OP_SUB: begin
               var_we_raw = (ctl.idx == 6'd1);
               var_wdata  = t0_ff - v;
            end
            OP_POSE: begin
               var_we_raw = 1'b1;
               var_waddr  = RAW_W'(a_ff) + RAW_W'(ctl.idx);
               var_wdata  = (ctl.idx == 6'd0) ? px_ff : ((ctl.idx == 6'd1) ? py_ff : pw_ff);
            end
            default: var_we_raw = 1'b0;
         endcase
      end else if (ctl.commit && (cmd_ff == CMD_WVAR)) begin
         var_we_raw = 1'b1;
         var_wdata  = data_ff;
      end
   end

   asi_ram #(.WIDTH(32), .DEPTH(NUM_VARIABLES)) u_var (
      .clock   (clock),
      .wr_en   (var_we_raw && (int'(var_waddr) < NUM_VARIABLES)),
      .wr_addr (var_waddr[VAR_AW-1:0]),
      .wr_data (var_wdata),
      .rd_addr (var_raddr[VAR_AW-1:0]),
      .rd_data (var_rd)
   );

   asi_ram #(.WIDTH(16), .DEPTH(NUM_SEQUENCES)) u_seq (
      .clock   (clock),
      .wr_en   (ctl.commit && (cmd_ff == CMD_WSEQ) && a_seq_ok),
      .wr_addr (a_ff[SEQ_AW-1:0]),
      .wr_data (data_ff[15:0]),
      .rd_addr (a_ff[SEQ_AW-1:0]),
      .rd_data (seq_rd)
   );

   asi_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_stk (
      .clock   (clock),
      .wr_en   (ctl.commit && exec_on && (op_ff == OP_CALL) && call_ok),
      .wr_addr (lvl_ff[STK_AW-1:0]),
      .wr_data (pc_ff),
      .rd_addr (lvl_dec[STK_AW-1:0]),
      .rd_data (stk_rd)
   );

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff  <= req_command;
         op_ff   <= req_opcode;
         a_ff    <= req_arg_a;
         b_ff    <= req_arg_b;
         c_ff    <= req_arg_c;
         data_ff <= req_data_value;
         sv_ff   <= req_status_value;
         tick_ff <= req_tick_now;
         sens_ff <= req_sensor_bits;
         px_ff   <= req_pose_x;
         py_ff   <= req_pose_y;
         pw_ff   <= req_pose_yaw;
      end
      if (ctl.step) begin
         if (ctl.idx == 6'd0) begin
            t0_ff <= v;
         end else begin
            t1_ff <= v;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= 16'd0;
         run_ff   <= 1'b0;
         zf_ff    <= 1'b0;
         nf_ff    <= 1'b0;
         cont_ff  <= 1'b0;
         dend_ff  <= 32'd0;
         dval_ff  <= 1'b0;
         pcode_ff <= 8'd0;
         ppend_ff <= 1'b0;
         aidle_ff <= 1'b1;
         apend_ff <= 1'b0;
         lvl_ff   <= '0;
         kind_ff  <= MK_NONE;
         npay_ff  <= 6'd0;
         for (int i = 0; i < NUM_SERVOS; i++) begin
            srv_ff[i] <= 1'b0;
         end
      end else if (ctl.commit) begin
         cont_ff <= 1'b0;
         kind_ff <= MK_NONE;
         npay_ff <= 6'd0;
         unique case (cmd_ff)
            CMD_EXEC: begin
               if (run_ff) begin
                  kind_ff <= pay_kind(op_ff);
                  npay_ff <= pay_count(op_ff, b_ff, MAX_TRAJ_POINTS);
                  pc_ff   <= nxt;
                  case (op_ff) inside
                     OP_NOP, OP_MOTEN, OP_MOTDIS, OP_EVENT, OP_MOV1, OP_MOV2, OP_MOV3,
                     OP_MOVI, OP_ADDI, OP_SUBI, OP_ADD, OP_SUB, OP_POSE, OP_SETPOSE,
                     OP_ADV, OP_DC, OP_DCB, OP_GPIO, OP_SRVSET, OP_ARMSD:
                        cont_ff <= 1'b1;
                     OP_DELAY: begin
                        if (!dval_ff) begin
                           dend_ff <= tick_ff + t0_ff;
                           dval_ff <= 1'b1;
                           pc_ff   <= pc_ff;
                        end else if (tick_ff >= dend_ff) begin
                           dval_ff <= 1'b0;
                           dend_ff <= 32'd0;
                           cont_ff <= 1'b1;
                        end else begin
                           pc_ff <= pc_ff;
                        end
                     end
                     OP_PROPEN, OP_PROPDIS: begin
                        ppend_ff <= 1'b1;
                        cont_ff  <= 1'b1;
                     end
                     OP_WAITARM: begin
                        if (aidle_ff && !apend_ff) cont_ff <= 1'b1;
                        else pc_ff <= pc_ff;
                     end
                     OP_WAITMOV: begin
                        if (!ppend_ff && (pcode_ff == PROP_STOPPED)) cont_ff <= 1'b1;
                        else pc_ff <= pc_ff;
                     end
                     OP_WAITSRV: begin
                        if (!srv_hit) cont_ff <= 1'b1;
                        else pc_ff <= pc_ff;
                     end
                     OP_POINT, OP_MOVE, OP_TRAJ, OP_ROT, OP_TRANS, OP_FACE, OP_REPOS,
                     OP_MANIN, OP_MANOUT:
                        ppend_ff <= 1'b1;
                     OP_RET: begin
                        if (lvl_ff == '0) begin
                           run_ff <= 1'b0;
                           pc_ff  <= pc_ff;
                        end else begin
                           lvl_ff  <= lvl_dec;
                           pc_ff   <= stk_rd + 16'd1;
                           cont_ff <= 1'b1;
                        end
                     end
                     OP_CALL: begin
                        cont_ff <= 1'b1;
                        if (call_ok) begin
                           lvl_ff <= lvl_ff + LVL_W'(1);
                           pc_ff  <= seq_val;
                        end
                     end
                     OP_ARMGO: begin
                        apend_ff <= 1'b1;
                        cont_ff  <= 1'b1;
                     end
                     OP_SENSOR: begin
                        zf_ff   <= (a_ff < 8'd32) && sens_ff[a_ff[4:0]];
                        cont_ff <= 1'b1;
                     end
                     OP_PROPST: begin
                        zf_ff   <= !(!ppend_ff && (pcode_ff == a_ff));
                        cont_ff <= 1'b1;
                     end
                     OP_CMP: begin
                        zf_ff   <= (t0_ff == t1_ff);
                        nf_ff   <= ($signed(t0_ff) < $signed(t1_ff));
                        cont_ff <= 1'b1;
                     end
                     OP_JMP: begin
                        pc_ff   <= target;
                        cont_ff <= 1'b1;
                     end
                     OP_JZ: begin
                        pc_ff   <= zf_ff ? nxt : target;
                        cont_ff <= 1'b1;
                     end
                     OP_JNZ: begin
                        pc_ff   <= zf_ff ? target : nxt;
                        cont_ff <= 1'b1;
                     end
                     OP_JN: begin
                        pc_ff   <= nf_ff ? nxt : target;
                        cont_ff <= 1'b1;
                     end
                     default: cont_ff <= 1'b0;
                  endcase
               end
            end
            CMD_START: begin
               run_ff <= 1'b1;
               pc_ff  <= seq_val;
            end
            CMD_ABORT: run_ff <= 1'b0;
            CMD_PROP: begin
               pcode_ff <= sv_ff;
               ppend_ff <= 1'b0;
            end
            CMD_ARM: begin
               aidle_ff <= sv_ff[0];
               apend_ff <= 1'b0;
            end
            CMD_SERVO: begin
               if (a_srv_ok) srv_ff[a_ff[SRV_AW-1:0]] <= sv_ff[0];
            end
            CMD_WVAR, CMD_WSEQ: cont_ff <= 1'b0;
            default: cont_ff <= 1'b0;
         endcase
      end
   end

   always_comb begin
      if (pw.use_var) begin
         word = (pw.low16 ? {8'd0, v[15:0], 8'd0} : v) | pw.cst;
      end else begin
         word = pw.cst;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ctl.load) begin
         rsp_pc_ff   <= pc_ff;
         rsp_run_ff  <= run_ff;
         rsp_cont_ff <= cont_ff;
         rsp_kind_ff <= kind_ff;
         rsp_word_ff <= (npay_ff == 6'd0) ? 32'd0 : word;
         rsp_last_ff <= (ctl.idx == num_words - 6'd1);
         rsp_z_ff    <= zf_ff;
         rsp_n_ff    <= nf_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_program_counter = rsp_pc_ff;
   assign rsp_running         = rsp_run_ff;
   assign rsp_continue_now    = rsp_cont_ff;
   assign rsp_message_kind    = rsp_kind_ff;
   assign rsp_payload_word    = rsp_word_ff;
   assign rsp_last_word       = rsp_last_ff;
   assign rsp_flag_zero       = rsp_z_ff;
   assign rsp_flag_negative   = rsp_n_ff;

endmodule

@@ sim/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import asi_pkg::*;

   localparam int NVARS    = 256;
   localparam int NSEQS    = 64;
   localparam int NSTACK   = 16;
   localparam int NSERVOS  = 16;
   localparam int MAXPTS   = 8;
   localparam int IDLE_LIMIT = 4000;

   typedef struct {
      logic [2:0]  cmd;
      logic [7:0]  op, a, b, c, sv;
      logic [31:0] data, tick, sensor, px, py, yaw;
   } cmd_item_t;

   typedef struct {
      logic [15:0] pc;
      logic        run, cont;
      logic [4:0]  kind;
      logic [31:0] word;
      logic        last, z, n;
   } msg_word_t;

   class interp_scoreboard;
      logic [31:0] vars [NVARS];
      logic [15:0] seq_start [NSEQS];
      logic [15:0] ret_stack [NSTACK];
      int          level;
      logic [15:0] pc;
      logic        run, fz, fn;
      logic [31:0] delay_end;
      logic        delay_on;
      logic [7:0]  prop_code;
      logic        prop_pend, arm_idle, arm_pend;
      logic        servo_busy [NSERVOS];
      logic [31:0] words [$];
      logic [4:0]  kind;
      msg_word_t   awaited [$];
      int          errors;

      function new();
         level = 0; pc = '0; run = 0; fz = 0; fn = 0;
         delay_end = '0; delay_on = 0; prop_code = '0; prop_pend = 0;
         arm_idle = 1; arm_pend = 0; errors = 0;
         foreach (servo_busy[i]) servo_busy[i] = 0;
      endfunction

      function logic [31:0] rd(int i);
         return (i < NVARS) ? vars[i] : 32'd0;
      endfunction

      function void wr(int i, logic [31:0] v);
         if (i < NVARS) vars[i] = v;
      endfunction

      function logic run_op(cmd_item_t r);
         logic [15:0] nxt, tgt;
         int a, b, c, np;
         logic [31:0] v1, v2;
         a = r.a; b = r.b; c = r.c;
         nxt = pc + 16'd1;
         tgt = {r.b, r.a};
         case (r.op)
            OP_NOP, OP_MOTEN, OP_MOTDIS, OP_EVENT: begin pc = nxt; return 1; end
            OP_MOV1: begin wr(a, rd(b)); pc = nxt; return 1; end
            OP_MOV2: begin
               wr(a, rd(b)); wr(a + 1, rd(b + 1)); pc = nxt; return 1;
            end
            OP_MOV3: begin
               wr(a, rd(b)); wr(a + 1, rd(b + 1)); wr(a + 2, rd(b + 2));
               pc = nxt; return 1;
            end
            OP_MOVI: begin wr(a, 32'(b)); pc = nxt; return 1; end
            OP_ADDI: begin wr(a, rd(a) + 32'(b)); pc = nxt; return 1; end
            OP_SUBI: begin wr(a, rd(a) - 32'(b)); pc = nxt; return 1; end
            OP_ADD: begin wr(a, rd(b) + rd(c)); pc = nxt; return 1; end
            OP_SUB: begin wr(a, rd(b) - rd(c)); pc = nxt; return 1; end
            OP_DELAY: begin
               if (!delay_on) begin
                  delay_end = r.tick + rd(a);
                  delay_on = 1;
                  return 0;
               end
               if (r.tick >= delay_end) begin
                  delay_on = 0; delay_end = '0; pc = nxt; return 1;
               end
               return 0;
            end
            OP_PROPEN, OP_PROPDIS: begin
               kind = MK_PROPEN;
               words.push_back(r.op == OP_PROPEN ? 32'd1 : 32'd0);
               prop_pend = 1; pc = nxt; return 1;
            end
            OP_WAITARM: begin
               if (arm_idle && !arm_pend) begin pc = nxt; return 1; end
               return 0;
            end
            OP_WAITMOV: begin
               if (!prop_pend && prop_code == PROP_STOPPED) begin pc = nxt; return 1; end
               return 0;
            end
            OP_WAITSRV: begin
               if (!(a < NSERVOS && servo_busy[a])) begin pc = nxt; return 1; end
               return 0;
            end
            OP_SETPOSE: begin
               kind = MK_SETPOSE;
               words.push_back(rd(a)); words.push_back(rd(a + 1));
               words.push_back(rd(a + 2));
               pc = nxt; return 1;
            end
            OP_POINT, OP_MOVE: begin
               kind = (r.op == OP_POINT) ? MK_POINT : MK_MOVE;
               words.push_back(rd(a)); words.push_back(rd(a + 1));
               words.push_back(rd(b)); words.push_back(rd(b + 1));
               words.push_back(rd(b + 2));
               prop_pend = 1; pc = nxt; return 0;
            end
            OP_TRAJ: begin
               np = (b > MAXPTS) ? MAXPTS : b;
               kind = MK_TRAJ;
               words.push_back(rd(c)); words.push_back(rd(c + 1));
               words.push_back(rd(c + 2));
               for (int i = 0; i < 2 * np; i++) words.push_back(rd(a + i));
               prop_pend = 1; pc = nxt; return 0;
            end
            OP_ROT, OP_TRANS, OP_FACE: begin
               kind = (r.op == OP_ROT) ? MK_ROT : (r.op == OP_TRANS) ? MK_TRANS : MK_FACE;
               words.push_back(rd(a)); words.push_back(rd(b));
               words.push_back(rd(b + 1)); words.push_back(rd(b + 2));
               prop_pend = 1; pc = nxt; return 0;
            end
            OP_REPOS: begin
               kind = MK_REPOS;
               words.push_back(rd(a)); words.push_back(rd(b));
               prop_pend = 1; pc = nxt; return 0;
            end
            OP_MANIN, OP_MANOUT: begin
               kind = (r.op == OP_MANIN) ? MK_MANIN : MK_MANOUT;
               prop_pend = 1; pc = nxt; return 0;
            end
            OP_CTRL: begin
               kind = MK_CTRL; words.push_back({16'd0, r.b, r.a}); pc = nxt; return 0;
            end
            OP_TGT: begin
               kind = MK_TGT;
               words.push_back(rd(a)); words.push_back(rd(a + 1));
               words.push_back(rd(a + 2)); words.push_back(rd(b));
               words.push_back(rd(b + 1)); words.push_back(32'd0);
               words.push_back(32'd0);
               pc = nxt; return 0;
            end
            OP_ADV: begin
               kind = MK_ADV; words.push_back({24'd0, r.a}); pc = nxt; return 1;
            end
            OP_MEASN: begin
               kind = MK_MEASN;
               words.push_back(rd(a)); words.push_back(rd(a + 1));
               pc = nxt; return 0;
            end
            OP_MEASP: begin
               kind = MK_MEASP;
               words.push_back(rd(a)); words.push_back(rd(a + 1));
               words.push_back(rd(b)); words.push_back(rd(b + 1));
               pc = nxt; return 0;
            end
            OP_RET: begin
               if (level == 0) begin run = 0; return 0; end
               level--;
               pc = ret_stack[level % NSTACK] + 16'd1;
               return 1;
            end
            OP_CALL: begin
               if (level >= NSTACK) begin pc = nxt; return 1; end
               ret_stack[level] = pc;
               level++;
               pc = (a < NSEQS) ? seq_start[a] : 16'd0;
               return 1;
            end
            OP_YIELD: begin pc = nxt; return 0; end
            OP_DC: begin
               v1 = rd(a);
               kind = MK_DC; words.push_back({8'd0, v1[15:0], 8'd0}); pc = nxt; return 1;
            end
            OP_DCB: begin
               v1 = rd(b);
               kind = MK_DC; words.push_back({8'd0, v1[15:0], r.a}); pc = nxt; return 1;
            end
            OP_GPIO: begin
               kind = MK_GPIO; words.push_back({16'd0, r.b, r.a}); pc = nxt; return 1;
            end
            OP_ARMGO: begin
               kind = MK_ARMGO; words.push_back({8'd0, r.c, r.b, r.a});
               arm_pend = 1; pc = nxt; return 1;
            end
            OP_SRVSET: begin
               v1 = rd(b);
               kind = MK_SERVO; words.push_back({r.c, v1[15:0], r.a}); pc = nxt; return 1;
            end
            OP_ARMSD: begin kind = MK_ARMSD; pc = nxt; return 1; end
            OP_SENSOR: begin
               fz = (a < 32) && r.sensor[a[4:0]]; pc = nxt; return 1;
            end
            OP_PROPST: begin
               fz = !(!prop_pend && prop_code == r.a); pc = nxt; return 1;
            end
            OP_POSE: begin
               wr(a, r.px); wr(a + 1, r.py); wr(a + 2, r.yaw); pc = nxt; return 1;
            end
            OP_CMP: begin
               v1 = rd(a); v2 = rd(b);
               fz = (v1 == v2);
               fn = ($signed(v1) < $signed(v2));
               pc = nxt; return 1;
            end
            OP_JMP: begin pc = tgt; return 1; end
            OP_JZ: begin pc = fz ? nxt : tgt; return 1; end
            OP_JNZ: begin pc = fz ? tgt : nxt; return 1; end
            OP_JN: begin pc = fn ? nxt : tgt; return 1; end
            default: begin pc = nxt; return 0; end
         endcase
      endfunction

      function void note_item(cmd_item_t r);
         logic cont;
         int cnt;
         msg_word_t e;
         words.delete();
         kind = MK_NONE;
         cont = 0;
         case (r.cmd)
            CMD_EXEC: if (run) cont = run_op(r);
            CMD_START: begin
               run = 1;
               pc = (r.a < NSEQS) ? seq_start[r.a] : 16'd0;
            end
            CMD_ABORT: run = 0;
            CMD_PROP: begin prop_code = r.sv; prop_pend = 0; end
            CMD_ARM: begin arm_idle = r.sv[0]; arm_pend = 0; end
            CMD_SERVO: if (r.a < NSERVOS) servo_busy[r.a] = r.sv[0];
            CMD_WVAR: wr(r.a, r.data);
            default: if (r.a < NSEQS) seq_start[r.a] = r.data[15:0];
         endcase
         cnt = (words.size() > 0) ? words.size() : 1;
         for (int k = 0; k < cnt; k++) begin
            e.pc = pc; e.run = run; e.cont = cont; e.kind = kind;
            e.word = (words.size() > 0) ? words[k] : 32'd0;
            e.last = (k == cnt - 1); e.z = fz; e.n = fn;
            awaited.push_back(e);
         end
      endfunction

      function void cmp(string name, logic [31:0] exp, logic [31:0] act);
         if (exp !== act) begin
            $error("%s: expected %0h, got %0h", name, exp, act);
            errors++;
         end
      endfunction

      function void check_word(msg_word_t got);
         msg_word_t e;
         if (awaited.size() == 0) begin
            $error("unexpected response item, pc %0h", got.pc);
            errors++;
            return;
         end
         e = awaited.pop_front();
         cmp("program_counter", 32'(e.pc), 32'(got.pc));
         cmp("running", 32'(e.run), 32'(got.run));
         cmp("continue_now", 32'(e.cont), 32'(got.cont));
         cmp("message_kind", 32'(e.kind), 32'(got.kind));
         cmp("payload_word", e.word, got.word);
         cmp("last_word", 32'(e.last), 32'(got.last));
         cmp("flag_zero", 32'(e.z), 32'(got.z));
         cmp("flag_negative", 32'(e.n), 32'(got.n));
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_command = '0;
   logic [7:0]  req_opcode = '0, req_arg_a = '0, req_arg_b = '0, req_arg_c = '0;
   logic [31:0] req_data_value = '0;
   logic [7:0]  req_status_value = '0;
   logic [31:0] req_tick_now = '0, req_sensor_bits = '0;
   logic [31:0] req_pose_x = '0, req_pose_y = '0, req_pose_yaw = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [15:0] rsp_program_counter;
   logic        rsp_running, rsp_continue_now;
   logic [4:0]  rsp_message_kind;
   logic [31:0] rsp_payload_word;
   logic        rsp_last_word, rsp_flag_zero, rsp_flag_negative;

   interp_scoreboard sb = new();
   logic quiet = 0;
   logic long_hold = 0;
   int   idle_cycles = 0;

   logic [7:0] op_set [] = '{OP_NOP, OP_MOV1, OP_MOV2, OP_MOV3, OP_MOVI, OP_ADDI,
      OP_SUBI, OP_ADD, OP_SUB, OP_RET, OP_CALL, OP_DELAY, OP_YIELD, OP_EVENT,
      OP_MOTEN, OP_PROPEN, OP_MOTDIS, OP_PROPDIS, OP_TRAJ, OP_WAITARM, OP_WAITMOV,
      OP_SETPOSE, OP_POINT, OP_MOVE, OP_ROT, OP_TRANS, OP_REPOS, OP_MANIN,
      OP_MANOUT, OP_CTRL, OP_TGT, OP_FACE, OP_ADV, OP_MEASN, OP_DC, OP_ARMGO,
      OP_SRVSET, OP_ARMSD, OP_DCB, OP_GPIO, OP_WAITSRV, OP_MEASP, OP_SENSOR,
      OP_PROPST, OP_POSE, OP_CMP, OP_JMP, OP_JZ, OP_JNZ, OP_JN};

   actuator_sequence_interpreter uut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      msg_word_t got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.pc = rsp_program_counter; got.run = rsp_running;
         got.cont = rsp_continue_now; got.kind = rsp_message_kind;
         got.word = rsp_payload_word; got.last = rsp_last_word;
         got.z = rsp_flag_zero; got.n = rsp_flag_negative;
         sb.check_word(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("** actuator_sequence_interpreter: FAILED **");
         $finish;
      end
   end

   // response back-pressure: random bursts, one long hold on request
   initial begin
      int len;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (300) @(negedge clock);
            rsp_stall <= 0;
            long_hold = 0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            len = $urandom_range(1, 18);
            rsp_stall <= 1;
            repeat (len) @(negedge clock);
            rsp_stall <= 0;
         end else begin
            rsp_stall <= 0;
            repeat ($urandom_range(0, 12)) @(negedge clock);
         end
      end
   end

   task automatic send(cmd_item_t r);
      @(negedge clock);
      req_valid <= 1;
      req_command <= r.cmd; req_opcode <= r.op;
      req_arg_a <= r.a; req_arg_b <= r.b; req_arg_c <= r.c;
      req_data_value <= r.data; req_status_value <= r.sv;
      req_tick_now <= r.tick; req_sensor_bits <= r.sensor;
      req_pose_x <= r.px; req_pose_y <= r.py; req_pose_yaw <= r.yaw;
      do @(posedge clock); while (req_stall);
      sb.note_item(r);
   endtask

   task automatic hold_req(int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 0;
      end
   endtask

   // variables 0..31 and 224..255 are loaded first
   function automatic logic [7:0] var_idx();
      return $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(240, 255));
   endfunction

   // sequence starts 0..23 are loaded first
   function automatic logic [7:0] seq_idx();
      return $urandom_range(0, 1) ? 8'($urandom_range(0, 23)) : 8'($urandom_range(NSEQS, 255));
   endfunction

   function automatic cmd_item_t noise_fields();
      cmd_item_t r;
      r.cmd = CMD_EXEC; r.op = OP_NOP;
      r.a = 8'($urandom); r.b = 8'($urandom); r.c = 8'($urandom);
      r.data = $urandom; r.sv = 8'($urandom);
      r.tick = $urandom; r.sensor = $urandom;
      r.px = $urandom; r.py = $urandom; r.yaw = $urandom;
      return r;
   endfunction

   function automatic cmd_item_t exec_item(logic [7:0] op, int a, int b, int c);
      cmd_item_t r;
      r = noise_fields();
      r.op = op; r.a = 8'(a); r.b = 8'(b); r.c = 8'(c);
      return r;
   endfunction

   function automatic cmd_item_t rand_item();
      cmd_item_t r;
      int p;
      r = noise_fields();
      p = $urandom_range(0, 99);
      if (!sb.run && p < 70) begin
         r.cmd = CMD_START;
         r.a = seq_idx();
      end else if (p < 75) begin
         r.cmd = 3'($urandom_range(1, 7));
         r.a = seq_idx();
         if (r.cmd == CMD_PROP && $urandom_range(0, 1)) r.sv = PROP_STOPPED;
      end else begin
         r.op = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                op_set[$urandom_range(0, op_set.size() - 1)];
         r.a = var_idx(); r.b = var_idx(); r.c = var_idx();
         if (r.op == OP_CALL) r.a = seq_idx();
      end
      return r;
   endfunction

   initial begin
      cmd_item_t r;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      for (int i = 0; i < 32; i++) begin
         r = noise_fields(); r.cmd = CMD_WVAR; r.a = 8'(i);
         send(r);
         r = noise_fields(); r.cmd = CMD_WVAR; r.a = 8'(NVARS - 1 - i);
         send(r);
      end
      for (int i = 0; i < 24; i++) begin
         r = noise_fields(); r.cmd = CMD_WSEQ; r.a = 8'(i);
         send(r);
      end

      send(exec_item(OP_NOP, 0, 0, 0));
      r = noise_fields(); r.cmd = CMD_START; r.a = 8'd255; send(r);
      r = noise_fields(); r.cmd = CMD_START; r.a = 8'd0; send(r);
      for (int i = 0; i < NSTACK + 1; i++)
         send(exec_item(OP_CALL, (i == 0) ? 255 : i - 1, 0, 0));
      send(exec_item(OP_TRAJ, 255, 255, 254));
      send(exec_item(OP_TRAJ, 0, 3, 0));
      send(exec_item(OP_SENSOR, 31, 0, 0));
      send(exec_item(OP_SENSOR, 32, 0, 0));
      send(exec_item(OP_CMP, 0, 255, 0));
      send(exec_item(8'd255, 0, 0, 0));

      // let the output side back up while items keep coming
      long_hold = 1;
      repeat (30) send(rand_item());
      hold_req(1);
      while (sb.awaited.size() != 0 || long_hold) @(posedge clock);

      for (int i = 0; i < 180; i++) begin
         if (i >= 150) quiet = 1;
         if (!quiet && $urandom_range(0, 7) == 0) hold_req($urandom_range(1, 18));
         send(rand_item());
      end
      hold_req(1);

      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0)
         $display("** actuator_sequence_interpreter: PASSED **");
      else
         $display("** actuator_sequence_interpreter: FAILED **");
      $finish;
   end
endmodule
